// ----- design/handle_table_mark_sweep_core_defines.svh -----
// Assertion macros for the handle table core.
`ifndef HANDLE_TABLE_MARK_SWEEP_CORE_DEFINES_SVH
`define HANDLE_TABLE_MARK_SWEEP_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HTMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HTMS_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HTMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define HTMS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- design/htms_pkg.sv -----
// Shared types and constants for the handle table core.
package htms_pkg;

  localparam int unsigned ACT_BITS = 2;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_MARK   = 2'd2,
    ACT_SWEEP  = 2'd3
  } action_t;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned FREED_W = 7;

endpackage

// ----- design/handle_table_mark_sweep_core.sv -----
// Handle table with allocate, lookup, mark and sweep over a slot memory.
//
// channel | dir | handshake           | beat
// in_     | in  | in_valid / in_stall | action, key_handle, user_active, last_in_list
// out_    | out | out_valid/out_stall | status, handle_out, slot_index, freed_count, list_done
//
// Every action scans all SLOTS entries of the slot memory, one read and at most
// one write-back per cycle: the result is loaded into the output register from
// S_PUSH after the last entry is checked, and the next beat is taken in S_IDLE.
// Reset is synchronous; per-entry valid bits make the whole table read as free.
// A new item is taken as soon as the previous result sits in the output register,
// even while out_stall holds it there; the scan then waits in S_PUSH until it drains.
`include "handle_table_mark_sweep_core_defines.svh"
module handle_table_mark_sweep_core
  import htms_pkg::*;
#(
  parameter int unsigned SLOTS       = 64,
  parameter int unsigned HANDLE_BITS = 16,
  parameter int unsigned USER_BITS   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_BITS-1:0]  in_action,
  input  logic [KEY_W-1:0]     in_key_handle,
  input  logic                 in_user_active,
  input  logic                 in_last_in_list,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_status,
  output logic [KEY_W-1:0]     out_handle_out,
  output logic [SLOT_W-1:0]    out_slot_index,
  output logic [FREED_W-1:0]   out_freed_count,
  output logic                 out_list_done
);

  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FW   = $clog2(SLOTS + 1);
  localparam int unsigned HB   = HANDLE_BITS;
  localparam int unsigned UB   = USER_BITS;
  localparam int unsigned DW   = HB + UB;
  localparam int unsigned KW   = (HB < KEY_W) ? HB : KEY_W;
  localparam int unsigned SW   = (IW < SLOT_W) ? IW : SLOT_W;
  localparam int unsigned CW   = (FW < FREED_W) ? FW : FREED_W;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
  localparam logic [HB-1:0] HMAX = {HB{1'b1}};
  localparam logic [UB-1:0] UMAX = {UB{1'b1}};

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PUSH} state_t;

  state_t           state_r;
  logic [IW-1:0]    rd_idx_r;
  logic             iss_done_r;
  logic             p_valid_r;
  logic [IW-1:0]    p_idx_r;
  logic [SLOTS-1:0] val_r;
  logic             rd_v_r;
  logic [DW-1:0]    rd_data_r;
  logic [DW-1:0]    mem [SLOTS];

  action_t          act_r;
  logic [HB-1:0]    key_r;
  logic             active_r;
  logic             done_r;

  logic [HB-1:0]    ctr_r, ctr_nxt, ctr_inc;
  logic             found_r, found_nxt;
  logic [IW-1:0]    res_slot_r, res_slot_nxt;
  logic [HB-1:0]    res_handle_r, res_handle_nxt;
  logic [FW-1:0]    freed_r, freed_nxt;

  logic             out_valid_r;
  logic             out_status_r;
  logic [KEY_W-1:0] out_handle_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [FREED_W-1:0] out_freed_r;
  logic             out_done_r;

  logic             accept;
  logic             push;
  logic [HB-1:0]    cur_h;
  logic [UB-1:0]    cur_u;
  logic             wr_en;
  logic [DW-1:0]    wr_data;

  logic             alloc_zero_wr;
  logic             rw_clash;
  logic             held_push;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign push     = (state_r == S_PUSH) && (!out_valid_r || !out_stall);

  // entries never written read as free with no users
  assign cur_h   = rd_v_r ? rd_data_r[DW-1:UB] : '0;
  assign cur_u   = rd_v_r ? rd_data_r[UB-1:0]  : '0;
  assign ctr_inc = (ctr_r == HMAX) ? HB'(1) : ctr_r + HB'(1);

  always_comb begin
    wr_en          = 1'b0;
    wr_data        = '0;
    found_nxt      = found_r;
    res_slot_nxt   = res_slot_r;
    res_handle_nxt = res_handle_r;
    ctr_nxt        = ctr_r;
    freed_nxt      = freed_r;
    if (p_valid_r) begin
      unique case (act_r)
        ACT_ALLOC: begin
          if (!found_r && cur_h == '0) begin
            wr_en          = 1'b1;
            wr_data        = {ctr_inc, UB'(0)};
            found_nxt      = 1'b1;
            res_slot_nxt   = p_idx_r;
            res_handle_nxt = ctr_inc;
            ctr_nxt        = ctr_inc;
          end
        end
        ACT_LOOKUP: begin
          if (!found_r && key_r != '0 && cur_h == key_r) begin
            found_nxt      = 1'b1;
            res_slot_nxt   = p_idx_r;
            res_handle_nxt = key_r;
          end
        end
        ACT_MARK: begin
          if (active_r && key_r != '0 && cur_h == key_r) begin
            wr_en     = 1'b1;
            wr_data   = {cur_h, (cur_u == UMAX) ? cur_u : cur_u + UB'(1)};
            found_nxt = 1'b1;
            if (!found_r) begin
              res_slot_nxt = p_idx_r;
            end
          end
        end
        ACT_SWEEP: begin
          wr_en = 1'b1;
          if (cur_h != '0 && cur_u == '0) begin
            wr_data   = '0;
            freed_nxt = freed_r + FW'(1);
          end else begin
            wr_data = {cur_h, UB'(0)};
          end
        end
        default: ;
      endcase
    end
    // a new beat starts from a clean result
    if (accept) begin
      found_nxt      = 1'b0;
      res_slot_nxt   = '0;
      res_handle_nxt = '0;
      freed_nxt      = '0;
    end
  end

  // slot memory: one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[p_idx_r] <= wr_data;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_idx_r     <= '0;
      iss_done_r   <= 1'b0;
      p_valid_r    <= 1'b0;
      val_r        <= '0;
      ctr_r        <= '0;
      found_r      <= 1'b0;
      freed_r      <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= 1'b0;
      out_handle_r <= '0;
      out_slot_r   <= '0;
      out_freed_r  <= '0;
      out_done_r   <= 1'b0;
    end else begin
      p_valid_r <= (state_r == S_SCAN) && !iss_done_r;
      if (wr_en) begin
        val_r[p_idx_r] <= 1'b1;
      end
      ctr_r   <= ctr_nxt;
      found_r <= found_nxt;
      freed_r <= freed_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
        out_done_r  <= done_r;
        unique case (act_r)
          ACT_ALLOC, ACT_LOOKUP: begin
            out_status_r <= !found_r;
            out_handle_r <= KEY_W'(res_handle_r[KW-1:0]);
            out_slot_r   <= SLOT_W'(res_slot_r[SW-1:0]);
            out_freed_r  <= '0;
          end
          ACT_MARK: begin
            out_status_r <= active_r && !found_r;
            out_handle_r <= '0;
            out_slot_r   <= SLOT_W'(res_slot_r[SW-1:0]);
            out_freed_r  <= '0;
          end
          ACT_SWEEP: begin
            out_status_r <= 1'b0;
            out_handle_r <= '0;
            out_slot_r   <= '0;
            out_freed_r  <= FREED_W'(freed_r[CW-1:0]);
          end
        endcase
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r    <= S_SCAN;
            rd_idx_r   <= '0;
            iss_done_r <= 1'b0;
          end
        end
        S_SCAN: begin
          if (!iss_done_r) begin
            if (rd_idx_r == LAST) begin
              iss_done_r <= 1'b1;
            end else begin
              rd_idx_r <= rd_idx_r + IW'(1);
            end
          end
          if (p_valid_r && p_idx_r == LAST) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r      <= rd_idx_r;
    rd_v_r       <= val_r[rd_idx_r];
    res_slot_r   <= res_slot_nxt;
    res_handle_r <= res_handle_nxt;
    if (accept) begin
      act_r    <= action_t'(in_action);
      key_r    <= HB'(in_key_handle[KW-1:0]);
      active_r <= in_user_active;
      done_r   <= in_last_in_list;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_handle_out  = out_handle_r;
  assign out_slot_index  = out_slot_r;
  assign out_freed_count = out_freed_r;
  assign out_list_done   = out_done_r;

  assign alloc_zero_wr = wr_en && act_r == ACT_ALLOC && wr_data[DW-1:UB] == '0;
  assign rw_clash      = wr_en && !iss_done_r && p_idx_r == rd_idx_r;
  assign held_push     = state_r == S_PUSH && out_valid_r && out_stall;

  `HTMS_NEVER(a_alloc_nonzero, clk, rst_n, alloc_zero_wr, "allocate wrote handle zero")
  `HTMS_NEVER(a_rw_same_entry, clk, rst_n, rw_clash, "write-back hits entry being read")
  `HTMS_ASSERT(a_push_waits, clk, rst_n, held_push |=> state_r == S_PUSH, "push over held beat")
  `HTMS_NEVER(a_freed_range, clk, rst_n, freed_r > FW'(SLOTS), "freed count beyond table size")
  `HTMS_NEVER(a_scan_no_out, clk, rst_n, p_valid_r && state_r != S_SCAN, "stray slot work")

endmodule
